/* design/jfe_pkg.sv */
// ----------------------------------------------------------------------------
// jfe_pkg
// Shared types and constants of the JPEG frame extractor: command codes,
// marker bytes, capacity limit and the records passed from front to back.
// ----------------------------------------------------------------------------
package jfe_pkg;

  localparam int unsigned CountW = 21;
  localparam int unsigned AddrW  = 32;
  localparam int unsigned ByteW  = 8;

  // Hard upper bound on the usable store size.
  localparam logic [CountW-1:0] MaxCapacity = 21'd1048576;

  localparam logic [ByteW-1:0] MarkerPrefix = 8'hFF;
  localparam logic [ByteW-1:0] MarkerSoi    = 8'hD8;
  localparam logic [ByteW-1:0] MarkerEoi    = 8'hD9;

  // Depth of the queue between front and back.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  typedef enum logic [1:0] {
    CmdData  = 2'd0,
    CmdStart = 2'd1,
    CmdAbort = 2'd2
  } cmd_e;

  // One result as the front decides it; the back adds the base address.
  typedef struct packed {
    logic              wr_en;
    logic [CountW-1:0] offset;
    logic [ByteW-1:0]  wr_byte;
    logic              frame_end;
    logic [CountW-1:0] size;
    logic              overflow;
  } result_t;

  // All results caused by one request: one or two.
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

/* design/jfe_if.sv */
// ----------------------------------------------------------------------------
// jfe_in_if / jfe_out_if
// Valid/ready channels carrying camera requests in and store writes out.
// ----------------------------------------------------------------------------
interface jfe_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] data_byte;

  modport source (output valid, command, data_byte, input ready);
  modport sink   (input valid, command, data_byte, output ready);
endinterface

interface jfe_out_if;
  logic        valid;
  logic        ready;
  logic        write_enable;
  logic [31:0] write_address;
  logic [7:0]  write_byte;
  logic        frame_end;
  logic [20:0] frame_size;
  logic        overflow;
  logic        last_of_run;

  modport source (output valid, write_enable, write_address, write_byte, frame_end,
                  frame_size, overflow, last_of_run, input ready);
  modport sink   (input valid, write_enable, write_address, write_byte, frame_end,
                  frame_size, overflow, last_of_run, output ready);
endinterface

/* design/jfe_front.sv */
// ----------------------------------------------------------------------------
// jfe_front
// Accepts requests, tracks the marker hunt and byte count, and queues the
// results that each request causes.
// ----------------------------------------------------------------------------
module jfe_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  jfe_in_if.sink                       req_i,
  input  logic [jfe_pkg::CountW-1:0]   cfg_cap_i,
  input  jfe_pkg::qstat_t              qstat_i,
  output logic                         push_o,
  output jfe_pkg::entry_t              entry_o
);

  logic                       armed_q, armed_d;
  logic                       in_frame_q, in_frame_d;
  logic                       prev_ff_q, prev_ff_d;
  logic [jfe_pkg::CountW-1:0] count_q, count_d;

  logic                       accept;
  logic [jfe_pkg::CountW-1:0] cap;
  logic [jfe_pkg::CountW-1:0] count_inc;
  logic                       is_ff;
  logic                       is_end;
  jfe_pkg::result_t           ovf_res;

  assign req_i.ready = !qstat_i.full;
  assign accept      = req_i.valid && req_i.ready;

  assign cap       = (cfg_cap_i > jfe_pkg::MaxCapacity) ? jfe_pkg::MaxCapacity : cfg_cap_i;
  assign count_inc = count_q + jfe_pkg::CountW'(1);
  assign is_ff     = (req_i.data_byte == jfe_pkg::MarkerPrefix);
  assign is_end    = prev_ff_q && (req_i.data_byte == jfe_pkg::MarkerEoi);

  always_comb begin
    ovf_res          = '0;
    ovf_res.overflow = 1'b1;
  end

  always_comb begin
    armed_d    = armed_q;
    in_frame_d = in_frame_q;
    prev_ff_d  = prev_ff_q;
    count_d    = count_q;
    push_o     = 1'b0;
    entry_o    = '0;
    if (accept) begin
      case (jfe_pkg::cmd_e'(req_i.command))
        jfe_pkg::CmdStart: begin
          armed_d    = 1'b1;
          in_frame_d = 1'b0;
          prev_ff_d  = 1'b0;
          count_d    = '0;
        end
        jfe_pkg::CmdAbort: begin
          armed_d = 1'b0;
        end
        jfe_pkg::CmdData: begin
          if (armed_q && !in_frame_q) begin
            if (prev_ff_q && (req_i.data_byte == jfe_pkg::MarkerSoi)) begin
              push_o = 1'b1;
              if (cap == '0) begin
                entry_o.r0 = ovf_res;
                armed_d    = 1'b0;
                in_frame_d = 1'b0;
                prev_ff_d  = 1'b0;
                count_d    = '0;
              end else begin
                entry_o.two          = 1'b1;
                entry_o.r0.wr_en     = 1'b1;
                entry_o.r0.offset    = '0;
                entry_o.r0.wr_byte   = jfe_pkg::MarkerPrefix;
                entry_o.r0.size      = jfe_pkg::CountW'(1);
                if (cap == jfe_pkg::CountW'(1)) begin
                  entry_o.r1 = ovf_res;
                  armed_d    = 1'b0;
                  in_frame_d = 1'b0;
                  prev_ff_d  = 1'b0;
                  count_d    = '0;
                end else begin
                  entry_o.r1.wr_en   = 1'b1;
                  entry_o.r1.offset  = jfe_pkg::CountW'(1);
                  entry_o.r1.wr_byte = jfe_pkg::MarkerSoi;
                  entry_o.r1.size    = jfe_pkg::CountW'(2);
                  in_frame_d         = 1'b1;
                  prev_ff_d          = 1'b0;
                  count_d            = jfe_pkg::CountW'(2);
                end
              end
            end else begin
              prev_ff_d = is_ff;
            end
          end else if (armed_q) begin
            push_o = 1'b1;
            if (count_q >= cap) begin
              entry_o.r0 = ovf_res;
              armed_d    = 1'b0;
              in_frame_d = 1'b0;
              prev_ff_d  = 1'b0;
              count_d    = '0;
            end else begin
              entry_o.r0.wr_en     = 1'b1;
              entry_o.r0.offset    = count_q;
              entry_o.r0.wr_byte   = req_i.data_byte;
              entry_o.r0.frame_end = is_end;
              entry_o.r0.size      = count_inc;
              count_d              = count_inc;
              prev_ff_d            = is_ff;
              if (is_end) begin
                armed_d    = 1'b0;
                in_frame_d = 1'b0;
                prev_ff_d  = 1'b0;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q    <= 1'b1;
      in_frame_q <= 1'b0;
      prev_ff_q  <= 1'b0;
      count_q    <= '0;
    end else begin
      armed_q    <= armed_d;
      in_frame_q <= in_frame_d;
      prev_ff_q  <= prev_ff_d;
      count_q    <= count_d;
    end
  end

endmodule

/* design/jfe_queue.sv */
// ----------------------------------------------------------------------------
// jfe_queue
// Short FIFO of result entries between the front and the back.
// ----------------------------------------------------------------------------
module jfe_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  jfe_pkg::entry_t entry_i,
  input  logic            pop_i,
  output jfe_pkg::entry_t head_o,
  output jfe_pkg::qstat_t qstat_o
);

  jfe_pkg::entry_t                mem_q [jfe_pkg::QueueDepth];
  logic [jfe_pkg::QueuePtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [jfe_pkg::QueueCntW-1:0]  cnt_q, cnt_d;
  logic                           do_push, do_pop;

  assign qstat_o.full  = (cnt_q == jfe_pkg::QueueCntW'(jfe_pkg::QueueDepth));
  assign qstat_o.empty = (cnt_q == '0);
  assign do_push       = push_i && !qstat_o.full;
  assign do_pop        = pop_i && !qstat_o.empty;
  assign head_o        = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + jfe_pkg::QueueCntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - jfe_pkg::QueueCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == jfe_pkg::QueuePtrW'(jfe_pkg::QueueDepth - 1))
                    ? '0 : wr_ptr_q + jfe_pkg::QueuePtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == jfe_pkg::QueuePtrW'(jfe_pkg::QueueDepth - 1))
                    ? '0 : rd_ptr_q + jfe_pkg::QueuePtrW'(1);
      end
    end
  end

endmodule

/* design/jfe_back.sv */
// ----------------------------------------------------------------------------
// jfe_back
// Drains queued entries one result per cycle when not stalled, forms the
// store address and holds each result in the output register until taken.
// ----------------------------------------------------------------------------
module jfe_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  jfe_pkg::entry_t            head_i,
  input  jfe_pkg::qstat_t            qstat_i,
  input  logic [jfe_pkg::AddrW-1:0]  cfg_base_i,
  output logic                       pop_o,
  jfe_out_if.source                  res_o
);

  logic                       valid_q, valid_d;
  logic                       sel_q, sel_d;
  logic                       wr_en_q;
  logic [jfe_pkg::AddrW-1:0]  addr_q;
  logic [jfe_pkg::ByteW-1:0]  byte_q;
  logic                       end_q;
  logic [jfe_pkg::CountW-1:0] size_q;
  logic                       ovf_q;
  logic                       last_q;

  logic                       load;
  logic                       last;
  jfe_pkg::result_t           cur;
  logic [jfe_pkg::AddrW-1:0]  addr;

  assign load  = !qstat_i.empty && (!valid_q || res_o.ready);
  assign cur   = sel_q ? head_i.r1 : head_i.r0;
  assign last  = !head_i.two || sel_q;
  assign pop_o = load && last;
  assign addr  = cur.wr_en
                 ? cfg_base_i + jfe_pkg::AddrW'(cur.offset)
                 : '0;

  always_comb begin
    valid_d = valid_q && !res_o.ready;
    sel_d   = sel_q;
    if (load) begin
      valid_d = 1'b1;
      sel_d   = !last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      sel_q   <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      wr_en_q <= cur.wr_en;
      addr_q  <= addr;
      byte_q  <= cur.wr_byte;
      end_q   <= cur.frame_end;
      size_q  <= cur.size;
      ovf_q   <= cur.overflow;
      last_q  <= last;
    end
  end

  assign res_o.valid         = valid_q;
  assign res_o.write_enable  = wr_en_q;
  assign res_o.write_address = addr_q;
  assign res_o.write_byte    = byte_q;
  assign res_o.frame_end     = end_q;
  assign res_o.frame_size    = size_q;
  assign res_o.overflow      = ovf_q;
  assign res_o.last_of_run   = last_q;

endmodule

/* design/jpeg_frame_extractor.sv */
// ----------------------------------------------------------------------------
// jpeg_frame_extractor
// Captures one JPEG frame from a camera byte stream into a frame store.
// ----------------------------------------------------------------------------
// The block takes one request per cycle: a camera byte, a start command or an
// abort command. While armed it hunts for the start marker FF D8 (the FF may
// come in an earlier request), then emits store writes at frame_base plus a
// running offset, both marker bytes first, until the end marker FF D9, which
// is flagged with frame_end and disarms the block until the next start. A
// byte that would land at or beyond the capacity (the smaller of
// frame_capacity and 1 MiB) yields a single overflow result instead and
// disarms. A request is accepted every cycle as long as the two-entry result
// queue has room; results leave through a registered output at one per cycle
// while the receiver takes them. The request that completes the start marker
// yields two results (one at capacity zero), any other request that gives a
// result yields one. A result passes the result queue and then the output
// register before it is offered. The user must write configuration through
// cfg_we_i while no results are pending; the block does not enforce it.
module jpeg_frame_extractor (
  input  logic        clk_i,
  input  logic        rst_ni,
  jfe_in_if.sink      req_i,
  jfe_out_if.source   res_o,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_wdata_i
);

  localparam logic IdxBase     = 1'b0;
  localparam logic IdxCapacity = 1'b1;

  logic [jfe_pkg::AddrW-1:0]  base_q;
  logic [jfe_pkg::CountW-1:0] cap_q;

  logic                       push;
  logic                       pop;
  jfe_pkg::entry_t            entry;
  jfe_pkg::entry_t            head;
  jfe_pkg::qstat_t            qstat;

  // Configuration registers: take the write on the edge, no read-back.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      cap_q  <= 21'd65536;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        IdxBase:     base_q <= cfg_wdata_i;
        IdxCapacity: cap_q  <= cfg_wdata_i[jfe_pkg::CountW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front: classify the request, advance the hunt and byte count, and queue
  // the results it causes.
  jfe_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_i),
    .cfg_cap_i (cap_q),
    .qstat_i   (qstat),
    .push_o    (push),
    .entry_o   (entry)
  );

  // Queue: decouple request acceptance from result delivery.
  jfe_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .head_o  (head),
    .qstat_o (qstat)
  );

  // Back: drain entries, add the base address and hold the output register.
  jfe_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .qstat_i    (qstat),
    .cfg_base_i (base_q),
    .pop_o      (pop),
    .res_o      (res_o)
  );

  // The front never pushes into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !qstat.full)
    else $error("result entry pushed into full queue");

  // An overflow result carries no store write.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.overflow) |-> (!res_o.write_enable && res_o.frame_size == '0))
    else $error("overflow result with write payload");

  // A frame end is always a write and always the last result of its request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.frame_end) |-> (res_o.write_enable && res_o.last_of_run))
    else $error("frame end without closing write");

  // A write never reports an empty or oversized store.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.write_enable) |->
      (res_o.frame_size != '0 && res_o.frame_size <= jfe_pkg::MaxCapacity))
    else $error("write with bad frame size");

endmodule

/* tb/sv/jfe_tb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jfe_tb_pkg
// Register indexes, the unused command code and the expected store write
// record shared by the frame extractor testbench and its checker.
// ----------------------------------------------------------------------------
package jfe_tb_pkg;
  import jfe_pkg::*;

  localparam logic RegFrameBase     = 1'b0;
  localparam logic RegFrameCapacity = 1'b1;

  // Code with no meaning: the block must ignore it.
  localparam logic [1:0] CmdReserved = 2'd3;

  typedef struct packed {
    logic              wr_en;
    logic [AddrW-1:0]  addr;
    logic [ByteW-1:0]  data;
    logic              frame_end;
    logic [CountW-1:0] size;
    logic              overflow;
    logic              last_of_run;
  } store_write_t;

endpackage

/* tb/sv/jfe_capture_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jfe_capture_checker
// Watches the request, result and register channels of the frame extractor,
// predicts the store writes of every accepted request and compares them.
// ----------------------------------------------------------------------------
module jfe_capture_checker
  import jfe_pkg::*;
  import jfe_tb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  jfe_in_if           req_i,
  jfe_out_if          res_i,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned effective_o,
  output int unsigned writes_o,
  output int unsigned frames_o,
  output int unsigned overflows_o
);

  logic [AddrW-1:0]  base_q;
  logic [CountW-1:0] capacity_q;
  logic              armed;
  logic              in_frame;
  logic              prev_ff;
  logic [CountW-1:0] byte_count;

  store_write_t expected_writes[$];
  int unsigned  fails;
  int unsigned  effective;
  int unsigned  writes_seen;
  int unsigned  frames_seen;
  int unsigned  overflows_seen;
  int unsigned  result_index;

  task automatic report_mismatch(input string msg);
    $display("[%0t] result %0d: %s", $time, result_index, msg);
    fails++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
  endtask

  // Write one byte to the store, or give the overflow result and disarm.
  task automatic store_byte(input logic [ByteW-1:0] b, input logic is_end, output logic ok);
    store_write_t      w;
    logic [CountW-1:0] cap_lim;
    w = '0;
    cap_lim = (capacity_q > MaxCapacity) ? MaxCapacity : capacity_q;
    if (byte_count >= cap_lim) begin
      w.overflow = 1'b1;
      armed      = 1'b0;
      in_frame   = 1'b0;
      prev_ff    = 1'b0;
      byte_count = '0;
      ok         = 1'b0;
    end else begin
      w.wr_en     = 1'b1;
      w.addr      = base_q + AddrW'(byte_count);
      w.data      = b;
      w.frame_end = is_end;
      byte_count  = byte_count + 1'b1;
      w.size      = byte_count;
      ok          = 1'b1;
    end
    expected_writes.push_back(w);
  endtask

  task automatic predict_request(input logic [1:0] cmd, input logic [ByteW-1:0] b);
    int unsigned  n0;
    logic         ok;
    logic         is_end;
    store_write_t tail;
    n0 = expected_writes.size();
    case (cmd)
      CmdStart: begin
        byte_count = '0;
        in_frame   = 1'b0;
        prev_ff    = 1'b0;
        armed      = 1'b1;
        effective++;
      end
      CmdAbort: begin
        armed = 1'b0;
        effective++;
      end
      CmdData: begin
        if (armed) begin
          effective++;
          if (!in_frame) begin
            if (prev_ff && b == MarkerSoi) begin
              byte_count = '0;
              store_byte(MarkerPrefix, 1'b0, ok);
              if (ok) begin
                store_byte(MarkerSoi, 1'b0, ok);
                if (ok) begin
                  in_frame = 1'b1;
                  prev_ff  = 1'b0;
                end
              end
            end else begin
              prev_ff = (b == MarkerPrefix);
            end
          end else begin
            is_end = prev_ff && b == MarkerEoi;
            store_byte(b, is_end, ok);
            if (ok) begin
              prev_ff = (b == MarkerPrefix);
              if (is_end) begin
                armed    = 1'b0;
                in_frame = 1'b0;
                prev_ff  = 1'b0;
              end
            end
          end
        end
      end
      default: ;
    endcase
    if (expected_writes.size() > n0) begin
      tail = expected_writes.pop_back();
      tail.last_of_run = 1'b1;
      expected_writes.push_back(tail);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    store_write_t want;
    if (!rst_ni) begin
      base_q         = '0;
      capacity_q     = 21'd65536;
      armed          = 1'b1;
      in_frame       = 1'b0;
      prev_ff        = 1'b0;
      byte_count     = '0;
      fails          = 0;
      effective      = 0;
      writes_seen    = 0;
      frames_seen    = 0;
      overflows_seen = 0;
      result_index   = 0;
      expected_writes.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == RegFrameBase) base_q = cfg_wdata_i;
        else capacity_q = cfg_wdata_i[CountW-1:0];
      end
      // Compare first so a result never meets an expectation pushed this edge.
      if (res_i.valid && res_i.ready) begin
        if (expected_writes.size() == 0) begin
          report_mismatch("result with no request pending");
        end else begin
          want = expected_writes.pop_front();
          check_field("write_enable", 32'(res_i.write_enable), 32'(want.wr_en));
          check_field("write_address", res_i.write_address, want.addr);
          check_field("write_byte", 32'(res_i.write_byte), 32'(want.data));
          check_field("frame_end", 32'(res_i.frame_end), 32'(want.frame_end));
          check_field("frame_size", 32'(res_i.frame_size), 32'(want.size));
          check_field("overflow", 32'(res_i.overflow), 32'(want.overflow));
          check_field("last_of_run", 32'(res_i.last_of_run), 32'(want.last_of_run));
          if (want.wr_en) writes_seen++;
          if (want.frame_end) frames_seen++;
          if (want.overflow) overflows_seen++;
        end
        result_index++;
      end
      if (req_i.valid && req_i.ready) predict_request(req_i.command, req_i.data_byte);
    end
    fail_count_o <= fails;
    pending_o    <= expected_writes.size();
    effective_o  <= effective;
    writes_o     <= writes_seen;
    frames_o     <= frames_seen;
    overflows_o  <= overflows_seen;
  end

endmodule

/* tb/sv/jpeg_frame_extractor_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpeg_frame_extractor_tb
// Drives camera bytes and capture commands into the frame extractor under a
// range of base and capacity settings, with random idling on both channels,
// and leaves prediction and comparison to the capture checker.
// ----------------------------------------------------------------------------
module jpeg_frame_extractor_tb;
  import jfe_pkg::*;
  import jfe_tb_pkg::*;

  localparam int unsigned IdlePct       = 28;
  localparam int unsigned HoldCycles    = 80;    // receiver hold-off for back pressure
  localparam int unsigned DrainCycles   = 6;     // settle time for requests that give no result
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned NumPhases     = 8;
  localparam int unsigned PhaseItems    = 100;

  logic clk = 1'b0;
  logic rst_n;

  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_wdata;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned effective;
  int unsigned writes_done;
  int unsigned frames_done;
  int unsigned overflows_done;

  int unsigned total_requests = 0;
  int unsigned settings_used  = 0;
  int unsigned quiet_cycles   = 0;
  bit          idle_on        = 1'b1;
  bit          hold_pending   = 1'b0;
  int unsigned hold_left      = 0;

  jfe_in_if  req_if ();
  jfe_out_if res_if ();

  jpeg_frame_extractor uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .req_i      (req_if),
    .res_o      (res_if),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_wdata_i(cfg_wdata)
  );

  jfe_capture_checker chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req_i       (req_if),
    .res_i       (res_if),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .effective_o (effective),
    .writes_o    (writes_done),
    .frames_o    (frames_done),
    .overflows_o (overflows_done)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog: end the run when nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WatchdogLimit) begin
        $display("Watchdog: no handshake for %0d cycles, %0d results pending",
                 WatchdogLimit, pending);
        $display("Test completed with failures");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Receiver: idle at random, or hold off for a whole stretch when asked.
  initial begin
    res_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        res_if.ready <= 1'b0;
        hold_left--;
      end else if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left    = HoldCycles - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= !idle_on || ($urandom_range(0, 99) >= IdlePct);
      end
    end
  end

  // Offer one request, with random idle cycles ahead of it, and hold it until
  // accepted. Valid stays high afterwards so back-to-back requests run at rate.
  task automatic send_request(input logic [1:0] cmd, input logic [ByteW-1:0] b);
    while (idle_on && $urandom_range(0, 99) < IdlePct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.command   <= cmd;
    req_if.data_byte <= b;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    total_requests++;
  endtask

  // Drop valid and wait until every expected result has come out, then let the
  // pipe settle for requests that give no result.
  task automatic wait_idle();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Write the base register and then the capacity register; call only while idle.
  task automatic apply_setting(input logic [31:0] base, input logic [31:0] cap);
    cfg_we    <= 1'b1;
    cfg_index <= RegFrameBase;
    cfg_wdata <= base;
    @(posedge clk);
    cfg_index <= RegFrameCapacity;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  // One random capture attempt: mostly well-formed frames with random bodies,
  // some aborted or left open, and now and then a burst of noise requests.
  task automatic send_frame_sequence();
    int unsigned      body;
    int unsigned      ending;
    logic [ByteW-1:0] b;
    if ($urandom_range(0, 99) < 12) begin
      repeat ($urandom_range(1, 4)) begin
        send_request(2'($urandom_range(0, 3)), ByteW'($urandom_range(0, 255)));
      end
    end else begin
      if ($urandom_range(0, 99) < 85) send_request(CmdStart, ByteW'($urandom_range(0, 255)));
      repeat ($urandom_range(0, 3)) send_request(CmdData, ByteW'($urandom_range(0, 255)));
      send_request(CmdData, MarkerPrefix);
      send_request(CmdData, MarkerSoi);
      body = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 24);
      repeat (body) begin
        b = ($urandom_range(0, 7) == 0) ? MarkerPrefix : ByteW'($urandom_range(0, 255));
        send_request(CmdData, b);
        // Occasionally follow a prefix with a start marker inside the frame.
        if (b == MarkerPrefix && $urandom_range(0, 3) == 0) send_request(CmdData, MarkerSoi);
      end
      ending = $urandom_range(0, 99);
      if (ending < 75) begin
        send_request(CmdData, MarkerPrefix);
        send_request(CmdData, MarkerEoi);
      end else if (ending < 85) begin
        send_request(CmdAbort, ByteW'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    logic [31:0] base;
    logic [31:0] cap;
    int unsigned goal;

    rst_n            = 1'b0;
    req_if.valid     <= 1'b0;
    req_if.command   <= CmdData;
    req_if.data_byte <= '0;
    cfg_we           <= 1'b0;
    cfg_index        <= RegFrameBase;
    cfg_wdata        <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset settings, base 0 and capacity 64 KiB.
    send_request(CmdData, 8'h00);        // hunting byte, no result
    send_request(CmdData, MarkerPrefix);
    send_request(CmdData, MarkerSoi);    // both marker bytes written
    send_request(CmdData, MarkerPrefix);
    send_request(CmdData, MarkerSoi);    // start marker inside a frame is data
    send_request(CmdData, MarkerPrefix);
    send_request(CmdData, MarkerEoi);    // frame end, disarm
    send_request(CmdData, 8'h55);        // ignored while disarmed
    send_request(CmdReserved, 8'hFF);    // unused code, ignored
    send_request(CmdStart, 8'h00);
    send_request(CmdData, MarkerPrefix);
    send_request(CmdReserved, 8'h00);    // must not break the pending prefix
    send_request(CmdData, MarkerSoi);
    send_request(CmdAbort, 8'h00);       // abort mid-frame
    send_request(CmdData, MarkerPrefix); // ignored after abort
    send_request(CmdStart, 8'hAA);
    send_request(CmdData, MarkerPrefix);
    send_request(CmdStart, 8'h00);       // restart clears the pending prefix
    send_request(CmdData, MarkerSoi);    // no marker now
    wait_idle();

    // Capacity two at the top of the address space: writes wrap, then overflow.
    apply_setting(32'hFFFF_FFFF, 32'd2);
    send_request(CmdData, MarkerPrefix);
    send_request(CmdData, MarkerSoi);
    send_request(CmdData, 8'h7F);
    wait_idle();

    // Capacity one: prefix fits, the second marker byte overflows.
    apply_setting(32'h0000_0000, 32'd1);
    send_request(CmdStart, 8'h00);
    send_request(CmdData, MarkerPrefix);
    send_request(CmdData, MarkerSoi);
    wait_idle();

    // Capacity zero: the first write overflows on its own.
    apply_setting(32'h1234_5678, 32'd0);
    send_request(CmdStart, 8'h00);
    send_request(CmdData, MarkerPrefix);
    send_request(CmdData, MarkerSoi);
    wait_idle();

    // Random phases, one register setting each.
    for (int unsigned p = 0; p < NumPhases; p++) begin
      case (p)
        0: begin base = 32'h0000_0000; cap = 32'd12;      end
        1: begin base = 32'hFFFF_FFF0; cap = 32'h1F_FFFF; end  // clamped to the hard limit
        2: begin base = $urandom();    cap = 32'd1048576; end
        3: begin base = 32'h8000_0000; cap = 32'd30;      end
        4: begin base = $urandom();    cap = 32'd2;       end
        5: begin base = 32'hFFFF_FFFF; cap = 32'd64;      end
        6: begin base = $urandom();    cap = 32'd8;       end
        default: begin base = $urandom(); cap = 32'd65536; end
      endcase
      apply_setting(base, cap);
      // Phase two runs flat out and starts with a long receiver hold-off, so
      // the result queue fills and the request side backs up.
      idle_on = (p != 2);
      if (p == 2) hold_pending = 1'b1;
      goal = effective + PhaseItems;
      while (effective < goal) send_frame_sequence();
      wait_idle();
    end
    idle_on = 1'b1;

    $display("Covered %0d requests (%0d acted on) over %0d register settings.",
             total_requests, effective, settings_used);
    $display("Checked %0d store writes, %0d complete frames and %0d overflows.",
             writes_done, frames_done, overflows_done);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
